// ===== rtl/core/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map core
// Payload structs, operation and status codes, controller states and the
// command and flag bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chm_pkg;

	// default sizes
	localparam int NUM_BUCKETS_DEF  = 64;
	localparam int POOL_ENTRIES_DEF = 256;
	localparam int VALUE_BITS_DEF   = 16;

	// fixed field widths
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 16;
	localparam int COUNT_W = 9;
	localparam int CFG_W   = 7;

	localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 7'd64;

	// remainder unit: key bits consumed per cycle
	localparam int MOD_DIGITS = 4;
	localparam int MOD_STEPS  = KEY_W / MOD_DIGITS;
	localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

	// operation codes
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_DEL   = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_DUP  = 2'd1;
	localparam logic [1:0] STAT_MISS = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value_in;
	} chm_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [VAL_W-1:0]   value_out;
		logic [COUNT_W-1:0] entry_count;
	} chm_result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_HEAD,
		ST_HEADW,
		ST_WALK,
		ST_CMP,
		ST_ACT,
		ST_FNEXT,
		ST_LINK,
		ST_FREE,
		ST_DONE
	} chm_state_t;

	// controller -> datapath
	typedef struct packed {
		logic       clr_step;
		logic       load_item;
		logic       mod_step;
		logic       head_rd;
		logic       head_ld;
		logic       node_rd;
		logic       node_adv;
		logic       node_hit;
		logic       set_stat;
		logic [1:0] stat;
		logic       add_fresh;
		logic       free_rd;
		logic       add_reuse;
		logic       add_link;
		logic       del_unlink;
		logic       del_free;
		logic       out_load;
	} chm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       clr_last;
		logic       mod_last;
		logic       cur_nil;
		logic       key_eq;
		logic       hit;
		logic       free_nil;
		logic       free_fresh;
		logic       out_free;
		logic [1:0] kind;
	} chm_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/chm_ram.sv =====
// ----------------------------------------------------------------------------
// chm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/chm_ctrl.sv =====
// ----------------------------------------------------------------------------
// chm_ctrl: operation sequencer of the chained hash map
// Clears the bucket table after reset, then for each item runs the remainder,
// walks the chain and issues the update and result commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire chm_pkg::chm_flags_t flags,
	output chm_pkg::chm_cmd_t        cmd
);

	import chm_pkg::*;

	chm_state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx   = state_q;
		cmd        = '0;
		item_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (flags.clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_nx      = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (flags.mod_last) state_nx = ST_HEAD;
			end
			ST_HEAD: begin
				cmd.head_rd = 1'b1;
				state_nx    = ST_HEADW;
			end
			ST_HEADW: begin
				cmd.head_ld = 1'b1;
				state_nx    = ST_WALK;
			end
			ST_WALK: begin
				if (flags.cur_nil) begin
					state_nx = ST_ACT;
				end else begin
					cmd.node_rd = 1'b1;
					state_nx    = ST_CMP;
				end
			end
			ST_CMP: begin
				if (flags.key_eq) begin
					cmd.node_hit = 1'b1;
					state_nx     = ST_ACT;
				end else begin
					cmd.node_adv = 1'b1;
					state_nx     = ST_WALK;
				end
			end
			ST_ACT: begin
				cmd.set_stat = 1'b1;
				state_nx     = ST_DONE;
				case (flags.kind)
					KIND_ADD: begin
						if (flags.hit) begin
							cmd.stat = STAT_DUP;
						end else if (flags.free_nil) begin
							cmd.stat = STAT_FULL;
						end else if (flags.free_fresh) begin
							cmd.stat      = STAT_OK;
							cmd.add_fresh = 1'b1;
							state_nx      = ST_LINK;
						end else begin
							cmd.stat    = STAT_OK;
							cmd.free_rd = 1'b1;
							state_nx    = ST_FNEXT;
						end
					end
					KIND_QUERY: begin
						cmd.stat = flags.hit ? STAT_OK : STAT_MISS;
					end
					KIND_DEL: begin
						if (flags.hit) begin
							cmd.stat       = STAT_OK;
							cmd.del_unlink = 1'b1;
							state_nx       = ST_FREE;
						end else begin
							cmd.stat = STAT_MISS;
						end
					end
					default: begin
						cmd.stat = STAT_MISS;
					end
				endcase
			end
			ST_FNEXT: begin
				cmd.add_reuse = 1'b1;
				state_nx      = ST_LINK;
			end
			ST_LINK: begin
				cmd.add_link = 1'b1;
				state_nx     = ST_DONE;
			end
			ST_FREE: begin
				cmd.del_free = 1'b1;
				state_nx     = ST_DONE;
			end
			ST_DONE: begin
				if (flags.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/chm_dp.sv =====
// ----------------------------------------------------------------------------
// chm_dp: datapath of the chained hash map
// Item registers, digit-serial remainder unit, chain walk registers, free
// list and entry pool memories, and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chm_dp #(
	parameter int NUM_BUCKETS  = chm_pkg::NUM_BUCKETS_DEF,
	parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF,
	parameter int VALUE_BITS   = chm_pkg::VALUE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire chm_pkg::chm_cmd_t         cmd,
	output chm_pkg::chm_flags_t            flags,
	input  wire chm_pkg::chm_item_t        item,
	input  wire logic [chm_pkg::CFG_W-1:0] bucket_count,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output chm_pkg::chm_result_t           result
);

	import chm_pkg::*;

	localparam int NW = $clog2(NUM_BUCKETS + 1);             // bucket count width
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int LW = $clog2(POOL_ENTRIES + 1);            // link incl. empty
	localparam int AW = $clog2(POOL_ENTRIES);                // pool address
	localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
	localparam int VB = VALUE_BITS;

	// item registers
	logic [1:0]       kind_q;
	logic [KEY_W-1:0] key_q;
	logic [VB-1:0]    val_q;

	// remainder unit
	logic [KEY_W-1:0]     key_sh_q;
	logic [NW-1:0]        rem_q, rem_nx, rem_t;
	logic [NW:0]          trial;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic [31:0]          n_sat;
	logic [NW-1:0]        n_eff;

	// walk and pool control
	logic [LW-1:0] cur_q, prev_q, nxt_q, alloc_q, free_head_q, fresh_q, held_q;
	logic          hit_q;
	logic [VB-1:0] vhit_q;
	logic [1:0]    stat_q;
	logic [BW-1:0] clr_q, bucket;

	// memory ports
	logic          head_we, next_we;
	logic [BW-1:0] head_waddr, head_raddr;
	logic [LW-1:0] head_wdata, head_rdata, next_wdata, next_rdata;
	logic [AW-1:0] next_waddr, next_raddr;
	logic          ent_we;
	logic [KEY_W-1:0] key_rdata;
	logic [VB-1:0]    val_rdata;

	// result register
	logic                 res_valid_q;
	chm_result_t          res_q;
	logic [VB+VAL_W-1:0]  vin_ext;
	logic [VB+VAL_W-1:0]  vout_ext;
	logic [LW+COUNT_W-1:0] cnt_ext;

	// effective bucket count: zero acts as one, saturate at table size
	always_comb begin
		n_sat = {{(32-CFG_W){1'b0}}, bucket_count};
		if (n_sat == 32'd0) begin
			n_sat = 32'd1;
		end else if (n_sat > 32'(NUM_BUCKETS)) begin
			n_sat = 32'(NUM_BUCKETS);
		end
		n_eff = n_sat[NW-1:0];
	end

	// restoring remainder, several key bits per cycle
	always_comb begin
		rem_t = rem_q;
		trial = '0;
		for (int i = 0; i < MOD_DIGITS; i++) begin
			trial = {rem_t, key_sh_q[KEY_W-1-i]};
			if (trial >= {1'b0, n_eff}) trial = trial - {1'b0, n_eff};
			rem_t = trial[NW-1:0];
		end
		rem_nx = rem_t;
	end

	assign bucket = rem_q[BW-1:0];
	assign vin_ext = {{VB{1'b0}}, item.value_in};

	// item, remainder and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q   <= item.kind;
			key_q    <= item.key;
			val_q    <= vin_ext[VB-1:0];
			key_sh_q <= item.key;
			rem_q    <= '0;
		end
		if (cmd.mod_step) begin
			rem_q    <= rem_nx;
			key_sh_q <= key_sh_q << MOD_DIGITS;
		end
		if (cmd.head_ld) begin
			cur_q  <= head_rdata;
			prev_q <= NIL;
		end
		if (cmd.node_adv) begin
			prev_q <= cur_q;
			cur_q  <= next_rdata;
		end
		if (cmd.node_hit) begin
			nxt_q  <= next_rdata;
			vhit_q <= val_rdata;
		end
		if (cmd.add_fresh || cmd.free_rd) begin
			alloc_q <= free_head_q;
		end
		if (cmd.set_stat) begin
			stat_q <= cmd.stat;
		end
	end

	// control registers: counters, free list head, hit flag, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q   <= '0;
			clr_q       <= '0;
			hit_q       <= 1'b0;
			free_head_q <= '0;
			fresh_q     <= '0;
			held_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				mod_cnt_q <= '0;
				hit_q     <= 1'b0;
			end
			if (cmd.mod_step) mod_cnt_q <= mod_cnt_q + 1'b1;
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.node_hit) hit_q <= 1'b1;
			if (cmd.add_fresh) begin
				free_head_q <= free_head_q + 1'b1;
				fresh_q     <= fresh_q + 1'b1;
			end
			if (cmd.add_reuse) free_head_q <= next_rdata;
			if (cmd.add_link) held_q <= held_q + 1'b1;
			if (cmd.del_free) begin
				free_head_q <= cur_q;
				if (held_q != '0) held_q <= held_q - 1'b1;
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// bucket head table writes: clearing pass, link or unlink of first entry
	always_comb begin
		head_we    = 1'b0;
		head_waddr = bucket;
		head_wdata = NIL;
		if (cmd.clr_step) begin
			head_we    = 1'b1;
			head_waddr = clr_q;
		end else if (cmd.add_link && prev_q == NIL) begin
			head_we    = 1'b1;
			head_wdata = alloc_q;
		end else if (cmd.del_unlink && prev_q == NIL) begin
			head_we    = 1'b1;
			head_wdata = nxt_q;
		end
	end
	assign head_raddr = bucket;

	// link table writes
	always_comb begin
		next_we    = 1'b0;
		next_waddr = prev_q[AW-1:0];
		next_wdata = NIL;
		if (cmd.add_fresh) begin
			next_we    = 1'b1;
			next_waddr = free_head_q[AW-1:0];
		end else if (cmd.add_reuse) begin
			next_we    = 1'b1;
			next_waddr = alloc_q[AW-1:0];
		end else if (cmd.add_link && prev_q != NIL) begin
			next_we    = 1'b1;
			next_wdata = alloc_q;
		end else if (cmd.del_unlink && prev_q != NIL) begin
			next_we    = 1'b1;
			next_wdata = nxt_q;
		end else if (cmd.del_free) begin
			next_we    = 1'b1;
			next_waddr = cur_q[AW-1:0];
			next_wdata = free_head_q;
		end
	end
	assign next_raddr = cmd.free_rd ? free_head_q[AW-1:0] : cur_q[AW-1:0];

	// key and value written when an entry is allocated
	assign ent_we = cmd.add_fresh || cmd.add_reuse;

	chm_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS), .AW(BW)) u_head (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	chm_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES), .AW(AW)) u_next (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.raddr (next_raddr),
		.rdata (next_rdata)
	);

	chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES), .AW(AW)) u_key (
		.clk   (clk),
		.we    (ent_we),
		.waddr (next_waddr),
		.wdata (key_q),
		.raddr (cur_q[AW-1:0]),
		.rdata (key_rdata)
	);

	chm_ram #(.WIDTH(VB), .DEPTH(POOL_ENTRIES), .AW(AW)) u_val (
		.clk   (clk),
		.we    (ent_we),
		.waddr (next_waddr),
		.wdata (val_q),
		.raddr (cur_q[AW-1:0]),
		.rdata (val_rdata)
	);

	// result register
	assign vout_ext = {{VAL_W{1'b0}}, vhit_q};
	assign cnt_ext  = {{COUNT_W{1'b0}}, held_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.status      <= stat_q;
			res_q.value_out   <= (stat_q == STAT_OK && kind_q != KIND_ADD) ?
			                     vout_ext[VAL_W-1:0] : '0;
			res_q.entry_count <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// status toward the controller
	always_comb begin
		flags            = '0;
		flags.clr_last   = (clr_q == BW'(NUM_BUCKETS - 1));
		flags.mod_last   = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
		flags.cur_nil    = (cur_q == NIL);
		flags.key_eq     = (key_rdata == key_q);
		flags.hit        = hit_q;
		flags.free_nil   = (free_head_q == NIL);
		flags.free_fresh = (free_head_q == fresh_q);
		flags.out_free   = !res_valid_q || !result_stall;
		flags.kind       = kind_q;
	end

endmodule

`default_nettype wire

// ===== rtl/core/chained_hash_map_int_key_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_int_key_core: separate-chaining hash map, 32-bit keys
// Items (add, query, delete) enter on the item channel: accepted when
// item_valid is high and item_stall low. Each item gives one result item
// (status, value, entry count) on the result channel, held in an output
// register until result_valid is high and result_stall low.
// The bucket count register is written on the cfg channel (cfg_ready is
// always high); write it only while no item is in flight.
// Steps: the digit-serial key remainder (4 bits a cycle), the bucket head
// read, a read and compare for each chain entry visited, then the update
// and the load of the result into the output register.
// One item is worked on at a time; the next is taken once the result is
// loaded, even while that result still waits for the receiver.
// Reset: all control state clears, then a clearing pass over all
// NUM_BUCKETS heads empties the bucket table; item_stall stays high meanwhile.
// A stalled receiver holds the result; a finished item waits for the output
// register before the block takes another.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_map_int_key_core #(
	parameter int NUM_BUCKETS  = chm_pkg::NUM_BUCKETS_DEF,
	parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF,
	parameter int VALUE_BITS   = chm_pkg::VALUE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_stall,
	input  wire chm_pkg::chm_item_t        item,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output chm_pkg::chm_result_t           result,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [chm_pkg::CFG_W-1:0] cfg_data
);

	import chm_pkg::*;

	logic [CFG_W-1:0] bucket_count_q;
	chm_cmd_t         cmd;
	chm_flags_t       flags;

	// bucket count register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			bucket_count_q <= cfg_data;
		end
	end

	chm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.flags      (flags),
		.cmd        (cmd)
	);

	chm_dp #(
		.NUM_BUCKETS  (NUM_BUCKETS),
		.POOL_ENTRIES (POOL_ENTRIES),
		.VALUE_BITS   (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.flags        (flags),
		.item         (item),
		.bucket_count (bucket_count_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== test/chained_hash_map_int_key_checker.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_int_key_checker: result predictor and comparator
// Mirrors the hash map state (chains, free list, bucket count), predicts the
// result of every accepted item and compares it field by field with the
// results leaving the block, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_map_int_key_checker
	import chm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire logic        item_stall,
	input  wire chm_item_t   item,
	input  wire logic        result_valid,
	input  wire logic        result_stall,
	input  wire chm_result_t result,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending_results
);

	localparam int NB   = NUM_BUCKETS_DEF;
	localparam int NP   = POOL_ENTRIES_DEF;
	localparam int NIL  = NP;

	// mirrored map state
	int              chain_head [NB];
	logic [KEY_W-1:0] slot_key  [NP];
	logic [VAL_W-1:0] slot_val  [NP];
	int              slot_next  [NP];
	int              free_top;
	int              held;
	logic [CFG_W-1:0] buckets;

	chm_result_t expected_results [$];

	assign pending_results = expected_results.size();

	function automatic chm_result_t apply_op(chm_item_t it);
		chm_result_t r;
		int n, b, cur, prev, hit, steps, e;
		n = buckets;
		if (n == 0) n = 1;
		if (n > NB) n = NB;
		b = it.key % n;
		cur = chain_head[b];
		prev = NIL;
		hit = NIL;
		steps = 0;
		while (cur < NIL && steps < NP && hit == NIL) begin
			if (slot_key[cur] == it.key) begin
				hit = cur;
			end else begin
				prev = cur;
				cur = slot_next[cur];
			end
			steps++;
		end
		r.status = STAT_MISS;
		r.value_out = '0;
		case (it.kind)
			KIND_ADD: begin
				if (hit < NIL) begin
					r.status = STAT_DUP;
				end else if (free_top >= NIL) begin
					r.status = STAT_FULL;
				end else begin
					e = free_top;
					free_top = slot_next[e];
					slot_key[e] = it.key;
					slot_val[e] = it.value_in;
					slot_next[e] = NIL;
					if (prev < NIL) slot_next[prev] = e;
					else chain_head[b] = e;
					held++;
					r.status = STAT_OK;
				end
			end
			KIND_QUERY: begin
				if (hit < NIL) begin
					r.status = STAT_OK;
					r.value_out = slot_val[hit];
				end
			end
			KIND_DEL: begin
				if (hit < NIL) begin
					if (prev < NIL) slot_next[prev] = slot_next[hit];
					else chain_head[b] = slot_next[hit];
					slot_next[hit] = free_top;
					free_top = hit;
					if (held > 0) held--;
					r.status = STAT_OK;
					r.value_out = slot_val[hit];
				end
			end
			default: ;
		endcase
		r.entry_count = held[COUNT_W-1:0];
		return r;
	endfunction

	// reset state
	initial begin
		for (int i = 0; i < NB; i++) chain_head[i] = NIL;
		for (int i = 0; i < NP; i++) begin
			slot_next[i] = i + 1;
			slot_key[i] = '0;
			slot_val[i] = '0;
		end
		free_top = 0;
		held = 0;
		buckets = BUCKET_COUNT_RST;
		fail_count = 0;
	end

	// watch the channels
	always @(posedge clk) begin
		chm_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) buckets = cfg_data;
			if (item_valid && !item_stall) expected_results.push_back(apply_op(item));
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, actual %p", $time, result);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (want.status !== result.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result.status);
						fail_count++;
					end
					if (want.value_out !== result.value_out) begin
						$display("%0t: value_out expected %h actual %h",
							$time, want.value_out, result.value_out);
						fail_count++;
					end
					if (want.entry_count !== result.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d",
							$time, want.entry_count, result.entry_count);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== test/chained_hash_map_int_key_core_test.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_int_key_core_test: top of the hash map core testbench
// Drives directed and random add, query, delete and unknown-kind items under
// several bucket counts and idling patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_map_int_key_core_test;
	import chm_pkg::*;

	// operation code outside the defined set
	localparam logic [1:0] KIND_BAD = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	chm_item_t   item;
	logic        result_valid;
	logic        result_stall;
	chm_result_t result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	int          fail_count;
	int          pending_results;

	int send_idle_pct;
	int recv_idle_pct;
	logic [KEY_W-1:0] key_pool [$];

	chained_hash_map_int_key_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	chained_hash_map_int_key_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_results(pending_results)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// receiver stalls at random
	always @(negedge clk)
		result_stall <= ($urandom_range(99) < recv_idle_pct);

	// send one item, idling first at random; valid is dropped by the next
	// idle cycle or by the drain
	task automatic send_op(logic [1:0] kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{kind: kind, key: key, value_in: val};
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_buckets(logic [CFG_W-1:0] n);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly keys seen before, so hits, duplicates and deletes happen
	function automatic logic [KEY_W-1:0] pick_key();
		if (key_pool.size() > 0 && $urandom_range(99) < 70)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		return ($urandom_range(1)) ? $urandom() : $urandom_range(300);
	endfunction

	task automatic random_phase(int count);
		logic [KEY_W-1:0] k;
		logic [1:0] kind;
		for (int i = 0; i < count; i++) begin
			k = pick_key();
			if (key_pool.size() < 64) key_pool.push_back(k);
			case ($urandom_range(19))
				0: kind = KIND_BAD;
				1, 2, 3, 4, 5, 6, 7, 8: kind = KIND_ADD;
				9, 10, 11, 12, 13: kind = KIND_QUERY;
				default: kind = KIND_DEL;
			endcase
			send_op(kind, k, 16'($urandom()));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 28;
		recv_idle_pct = 86;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, every operation, unknown kind, refusals
		send_op(KIND_QUERY, 32'd5, 16'hFFFF);
		send_op(KIND_ADD, 32'd0, 16'h0000);
		send_op(KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF);
		send_op(KIND_ADD, 32'd64, 16'h1234);
		send_op(KIND_ADD, 32'd128, 16'h5678);
		send_op(KIND_ADD, 32'd0, 16'hAAAA);
		send_op(KIND_QUERY, 32'd64, 16'd0);
		send_op(KIND_DEL, 32'd64, 16'd0);
		send_op(KIND_QUERY, 32'd128, 16'd0);
		send_op(KIND_DEL, 32'd64, 16'd0);
		send_op(KIND_BAD, 32'd0, 16'hFFFF);
		send_op(KIND_DEL, 32'hFFFF_FFFF, 16'd0);
		drain_results();

		// zero and oversize counts; old entries may become unreachable
		write_buckets(7'd0);
		send_op(KIND_ADD, 32'd128, 16'h0001);
		send_op(KIND_QUERY, 32'd0, 16'd0);
		drain_results();
		write_buckets(7'd127);
		send_op(KIND_QUERY, 32'd128, 16'd0);
		drain_results();

		// fill the pool to reach pool full
		write_buckets(7'd1);
		for (int i = 0; i < 258; i++) send_op(KIND_ADD, 32'h1000 + i, i[15:0]);
		send_op(KIND_QUERY, 32'h1000, 16'd0);
		for (int i = 0; i < 258; i++) send_op(KIND_DEL, 32'h1000 + i, 16'd0);
		drain_results();

		// random phases under changing bucket counts and idling
		write_buckets(7'd64);
		random_phase(300);
		drain_results();
		write_buckets(7'd7);
		random_phase(300);
		drain_results();
		send_idle_pct = 86;
		recv_idle_pct = 28;
		write_buckets(7'd1);
		random_phase(200);
		drain_results();
		write_buckets(7'd33);
		random_phase(300);
		drain_results();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_buckets(7'd64);
		random_phase(270);
		drain_results();

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#100ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
